/* rtl/core/kpc_pkg.sv */
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

   localparam int WindowWidth = 7;
   localparam int HoldWidth   = 6;
   localparam int DwinWidth   = 5;
   localparam int CsrWidth    = 6;
   localparam int CsrAddrWidth = 2;

   typedef logic signed [WindowWidth-1:0] window_type;

   localparam window_type WINDOW_FLOOR = -7'sd10;

   localparam logic [DwinWidth-1:0] DOUBLE_WINDOW_RESET  = 5'd5;
   localparam logic [HoldWidth-1:0] LONG_THRESHOLD_RESET = 6'd10;
   localparam logic [HoldWidth-1:0] HOLD_LIMIT_RESET     = 6'd30;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_DOUBLE_WINDOW  = 2'd0,
      CSR_LONG_THRESHOLD = 2'd1,
      CSR_HOLD_LIMIT     = 2'd2
   } csr_addr_type;

   typedef enum logic [1:0] {
      KEY_NONE  = 2'd0,
      KEY_ENTER = 2'd1,
      KEY_DOWN  = 2'd2
   } key_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_LONG   = 2'd2,
      KIND_DOUBLE = 2'd3
   } kind_type;

   // result word, key_code in the low bits
   typedef struct packed {
      kind_type press_kind;
      key_type  key_code;
   } rsp_type;

endpackage

/* rtl/core/key_press_classifier.sv */
// ----------------------------------------------------------------------------
// key_press_classifier
// Classifies enter / down key presses as single, long or double, one tick
// per input word, with a two-entry result buffer toward the consumer.
// ----------------------------------------------------------------------------
// The result word of an accepted tick is registered into the head register, or
// into the skid entry, a second result register that lets one more tick in
// while a result waits. Throughput: one tick word per cycle while the skid is
// empty; the state updates in one pass of counter and compare logic at acceptance.
// Reset (synchronous, active high) clears all key state, the result buffer
// and loads the register defaults (window 5, long threshold 10, limit 30).
module key_press_classifier
   import kpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration write port
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrWidth-1:0]     csr_wdata,
   // tick words in
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] enter_irq, [1] enter_pressed, [2] down_irq, [3] down_pressed,
   // [4] report_taken, [7:5] zero
   input  logic [7:0]              req_tdata,
   // result words out
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [1:0] key_code, [3:2] press_kind, [7:4] zero
   output logic [7:0]              rsp_tdata
);

   // configuration registers
   logic [DwinWidth-1:0] dwin_ff;
   logic [HoldWidth-1:0] long_thr_ff;
   logic [HoldWidth-1:0] hold_lim_ff;

   // classifier state
   logic       enter_pend_ff, enter_pend_in;
   logic       down_pend_ff,  down_pend_in;
   logic [HoldWidth-1:0] hold_ff, hold_in;
   window_type window_ff, window_in;
   logic       armed_ff, armed_in;
   logic       short_ff, short_in;
   key_type    rkey_ff, rkey_in;
   kind_type   rkind_ff, rkind_in;

   // result buffer: head register and one skid entry
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff,  out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;

   logic    accept;
   logic    pop;
   rsp_type result;

   // unpacked tick fields
   logic e_irq, e_held, d_irq, d_held, taken;

   // classify datapath
   logic                 served;
   logic                 held;
   key_type              key;
   logic [HoldWidth:0]   hold_inc;
   logic [HoldWidth-1:0] hold_sat;
   window_type           window_dec;

   assign e_irq  = req_tdata[0];
   assign e_held = req_tdata[1];
   assign d_irq  = req_tdata[2];
   assign d_held = req_tdata[3];
   assign taken  = req_tdata[4];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_data_ff};

   // one tick: acknowledge, latch interrupts, then classify the served key
   always_comb begin
      rkey_in       = rkey_ff;
      rkind_in      = rkind_ff;
      enter_pend_in = enter_pend_ff | e_irq;
      down_pend_in  = down_pend_ff | d_irq;
      hold_in       = hold_ff;
      window_in     = window_ff;
      armed_in      = armed_ff;
      short_in      = short_ff;

      if (taken) begin
         rkey_in  = KEY_NONE;
         rkind_in = KIND_NONE;
      end

      // enter wins when both keys are pending
      served = enter_pend_in || down_pend_in;
      held   = enter_pend_in ? e_held : d_held;
      key    = enter_pend_in ? KEY_ENTER : KEY_DOWN;

      // saturating hold count, computed one bit wider to catch the carry
      hold_inc = {1'b0, hold_ff} + {{HoldWidth{1'b0}}, 1'b1};
      hold_sat = (hold_inc > {1'b0, hold_lim_ff}) ? hold_lim_ff
                                                  : hold_inc[HoldWidth-1:0];
      // window countdown with floor
      window_dec = window_ff - window_type'(1);
      if (window_dec < WINDOW_FLOOR) begin
         window_dec = WINDOW_FLOOR;
      end

      if (served) begin
         if (held) begin
            rkey_in = key;
            hold_in = hold_sat;
            if ((window_dec > window_type'(0)) && armed_ff) begin
               // second press inside the window
               armed_in  = 1'b0;
               short_in  = 1'b0;
               rkind_in  = KIND_DOUBLE;
               window_in = window_dec;
            end else begin
               window_in = window_type'({2'b00, dwin_ff});
               if (hold_sat > long_thr_ff) begin
                  short_in = 1'b0;
                  rkind_in = KIND_LONG;
               end else begin
                  short_in = 1'b1;
               end
            end
         end else begin
            // release: arm unless a double is still on report
            if (rkind_in != KIND_DOUBLE) begin
               armed_in = 1'b1;
            end else begin
               armed_in  = 1'b0;
               window_in = window_type'({2'b00, dwin_ff});
            end
            hold_in = '0;
            if (key == KEY_ENTER) begin
               enter_pend_in = 1'b0;
            end else begin
               down_pend_in = 1'b0;
            end
            if (short_ff) begin
               short_in = 1'b0;
               rkey_in  = key;
               rkind_in = KIND_SINGLE;
            end else begin
               rkey_in  = KEY_NONE;
               rkind_in = KIND_NONE;
            end
         end
      end

      result.key_code   = rkey_in;
      result.press_kind = rkind_in;
   end

   // result buffer: fill head first, park in skid while head is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_data_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwin_ff       <= DOUBLE_WINDOW_RESET;
         long_thr_ff   <= LONG_THRESHOLD_RESET;
         hold_lim_ff   <= HOLD_LIMIT_RESET;
         enter_pend_ff <= 1'b0;
         down_pend_ff  <= 1'b0;
         hold_ff       <= '0;
         window_ff     <= window_type'({2'b00, DOUBLE_WINDOW_RESET});
         armed_ff      <= 1'b0;
         short_ff      <= 1'b0;
         rkey_ff       <= KEY_NONE;
         rkind_ff      <= KIND_NONE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DOUBLE_WINDOW:  dwin_ff     <= csr_wdata[DwinWidth-1:0];
               CSR_LONG_THRESHOLD: long_thr_ff <= csr_wdata;
               CSR_HOLD_LIMIT:     hold_lim_ff <= csr_wdata;
               default: ; // drop writes beyond the register list
            endcase
         end
         if (accept) begin
            enter_pend_ff <= enter_pend_in;
            down_pend_ff  <= down_pend_in;
            hold_ff       <= hold_in;
            window_ff     <= window_in;
            armed_ff      <= armed_in;
            short_ff      <= short_in;
            rkey_ff       <= rkey_in;
            rkind_ff      <= rkind_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
